// ----- src/cldbf_pkg.sv -----
// Shared types and constants for the character LCD expander byte formatter.
package cldbf_pkg;

	// Request function codes
	localparam logic [1:0] FN_CMD    = 2'd0;
	localparam logic [1:0] FN_CHAR   = 2'd1;
	localparam logic [1:0] FN_CURSOR = 2'd2;
	localparam logic [1:0] FN_NUMBER = 2'd3;

	// Field widths
	localparam int VAL_W   = 16;
	localparam int COL_W   = 6;
	localparam int DIGITS  = 5;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int IMG_W   = 8 * DIGITS;
	localparam int NCNT_W  = 4;

	// Expander control nibble bits
	localparam logic BL_ON = 1'b1;
	localparam logic EN_ON = 1'b1;
	localparam logic RW_WR = 1'b0;

	// High nibble of an ASCII decimal digit
	localparam logic [3:0] ASCII_HI = 4'h3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [VAL_W-1:0] value;
		logic             row;
		logic [COL_W-1:0] col;
	} req_t;

	typedef struct packed {
		logic [7:0] strobe_byte;
		logic [7:0] release_byte;
		logic       last;
	} res_t;

	// Load command from the controller to the nibble emitter
	typedef struct packed {
		logic              load;
		logic [IMG_W-1:0]  image;
		logic [NCNT_W-1:0] cnt;
		logic              skip;
		logic              rs;
	} emit_ld_t;

endpackage

// ----- src/cldbf_bcd.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module cldbf_bcd
	import cldbf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [VAL_W-1:0] bin,
	output logic             done,
	output logic [BCD_W-1:0] bcd
);

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic [VAL_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [BCD_W-1:0] adj;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Control: bit counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (go) begin
				cnt_q <= CNT_W'(VAL_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Datapath: shift one binary bit into the digit register
	always_ff @(posedge clk) begin
		if (go) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VAL_W-1]};
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ----- src/cldbf_emit.sv -----
// Nibble emitter: shifts the byte image out one nibble per cycle as expander bytes.
module cldbf_emit
	import cldbf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  emit_ld_t ld,
	output logic     strobe,
	output res_t     result
);

	logic [IMG_W-1:0]  sr_q;
	logic [NCNT_W-1:0] cnt_q;
	logic              skip_q;
	logic              rs_q;
	logic              active;
	logic              skip_now;
	logic [3:0]        nib;

	assign active   = (cnt_q != '0);
	// Leading zero digit of a number: drop its two nibbles, keep at least one digit
	assign skip_now = active && skip_q && (cnt_q > NCNT_W'(2))
		&& (sr_q[IMG_W-5 -: 4] == 4'h0);
	assign nib      = sr_q[IMG_W-1 -: 4];

	// Control: nibble count and zero suppression flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			skip_q <= 1'b0;
		end else if (ld.load) begin
			cnt_q  <= ld.cnt;
			skip_q <= ld.skip;
		end else if (skip_now) begin
			cnt_q  <= cnt_q - NCNT_W'(2);
		end else if (active) begin
			cnt_q  <= cnt_q - NCNT_W'(1);
			skip_q <= 1'b0;
		end
	end

	// Datapath: nibble shift register
	always_ff @(posedge clk) begin
		if (ld.load) begin
			sr_q <= ld.image;
			rs_q <= ld.rs;
		end else if (skip_now) begin
			sr_q <= {sr_q[IMG_W-9:0], 8'h00};
		end else if (active) begin
			sr_q <= {sr_q[IMG_W-5:0], 4'h0};
		end
	end

	// Expander bytes for the current nibble
	always_comb begin
		strobe              = active && !skip_now;
		result.strobe_byte  = {nib, BL_ON, EN_ON, RW_WR, rs_q};
		result.release_byte = {nib, BL_ON, 1'b0, RW_WR, rs_q};
		result.last         = strobe && (cnt_q == NCNT_W'(1));
	end

endmodule

// ----- src/char_lcd_expander_byte_formatter.sv -----
// A byte request loads the emitter on acceptance and gives its two transfers, one per cycle.
// A number request runs the bit-serial BCD conversion and then loads the emitter; up to 4
// leading zero digits are skipped, then one transfer per cycle (2 per digit, up to 10).
// busy stays high until the last transfer; the next request is taken the cycle after.
// Reset clears the controller and the counters of the converter and emitter; results cannot be stalled.
module char_lcd_expander_byte_formatter
	import cldbf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic strobe,
	output res_t result
);

	state_t           state_q;
	state_t           state_d;
	logic             accept;
	logic             conv_go;
	logic             conv_done;
	logic [BCD_W-1:0] bcd;
	logic [7:0]       byte_val;
	logic             byte_rs;
	emit_ld_t         ld;

	assign accept = start && !busy;

	// Byte for command, character and cursor requests
	always_comb begin
		case (request.func)
			FN_CMD: begin
				byte_val = request.value[7:0];
				byte_rs  = 1'b0;
			end
			FN_CHAR: begin
				byte_val = request.value[7:0];
				byte_rs  = 1'b1;
			end
			FN_CURSOR: begin
				byte_val = {1'b1, request.row, request.col};
				byte_rs  = 1'b0;
			end
			default: begin
				byte_val = request.value[7:0];
				byte_rs  = 1'b1;
			end
		endcase
	end

	cldbf_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (conv_go),
		.bin    (request.value),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (request.func == FN_NUMBER) ? ST_CONV : ST_EMIT;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (strobe && result.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs of the controller: busy, converter start, emitter load
	always_comb begin
		busy     = (state_q != ST_IDLE);
		conv_go  = 1'b0;
		ld.load  = 1'b0;
		ld.image = {byte_val, {(IMG_W-8){1'b0}}};
		ld.cnt   = NCNT_W'(2);
		ld.skip  = 1'b0;
		ld.rs    = byte_rs;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					conv_go = (request.func == FN_NUMBER);
					ld.load = (request.func != FN_NUMBER);
				end
			end
			ST_CONV: begin
				ld.load  = conv_done;
				ld.image = {ASCII_HI, bcd[19:16], ASCII_HI, bcd[15:12], ASCII_HI,
					bcd[11:8], ASCII_HI, bcd[7:4], ASCII_HI, bcd[3:0]};
				ld.cnt   = NCNT_W'(2 * DIGITS);
				ld.skip  = 1'b1;
				ld.rs    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	cldbf_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld),
		.strobe (strobe),
		.result (result)
	);

	// Transfers only while a request is in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result transfer while idle");

	// An accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("not busy after accepting a request");

	// Nothing follows the final transfer of a request
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe && !busy)
		else $error("transfer after the final one");

	// No transfer during number conversion
	a_conv_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !strobe)
		else $error("transfer during conversion");

endmodule
